// File: rtl/msf_pkg.sv
// ----------------------------------------------------------------------------
// msf_pkg
// Shared widths, constants and handshake types of the mean-shift pixel filter.
// ----------------------------------------------------------------------------
package msf_pkg;

  // Default sizes of the frame store and iteration limit
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_PASSES_DEF = 100;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPATIAL_RADIUS  = 2'd0;
  localparam logic [1:0] CFG_COLOR_RADIUS_SQ = 2'd1;
  localparam logic [1:0] CFG_FRAME_WIDTH     = 2'd2;
  localparam logic [1:0] CFG_FRAME_HEIGHT    = 2'd3;

  // Configuration widths and reset values
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;
  localparam int RAD_W      = 4;
  localparam int DIM_W      = 9;
  localparam logic [RAD_W-1:0]      RAD_RST  = 4'd4;
  localparam logic [CFG_DATA_W-1:0] CRAD_RST = 34'd4194304;
  localparam logic [DIM_W-1:0]      DIM_RST  = 9'd256;

  // Pixel and datapath widths
  localparam int PIX_W   = 16;             // one Lab channel, Q8.8
  localparam int WORD_W  = 3 * PIX_W;      // one stored pixel
  localparam int CRD_W   = 9;              // window coordinate
  localparam int CNT_W   = 10;             // pixel count, up to 31 x 31
  localparam int SUM_W   = 20;             // sum of coordinates
  localparam int ACC_W   = 27;             // signed sum of a color channel
  localparam int DV_W    = 28;             // dividend of the rounding division
  localparam int DVS_W   = CNT_W + 1;      // divisor, twice the count
  localparam int DIV_CNT_W = 5;
  localparam int SQ_W    = 32;             // square of one 17-bit difference
  localparam int DIST_W  = 34;             // sum of three squares
  localparam int SHIFT_W = 40;
  localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 40'd196608;  // 3.0 in Q.16
  localparam int PASS_W  = 8;

  // Divider handshake
  typedef struct packed {
    logic             start;
    logic [DV_W-1:0]  dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/msf_fmem.sv
// ----------------------------------------------------------------------------
// msf_fmem
// Frame store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module msf_fmem #(
  parameter int DEPTH = msf_pkg::MAX_WIDTH_DEF * msf_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = 16
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [msf_pkg::WORD_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr,
  output logic [msf_pkg::WORD_W-1:0]  rdata
);

  logic [msf_pkg::WORD_W-1:0] mem [DEPTH];
  logic [msf_pkg::WORD_W-1:0] rdata_r;

  // Write a word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read a word; the read data is registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/msf_div.sv
// ----------------------------------------------------------------------------
// msf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msf_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msf_pkg::div_req_t req,
  output msf_pkg::div_rsp_t rsp
);

  logic [msf_pkg::DVS_W-1:0]     dvs_r;
  logic [msf_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [msf_pkg::DV_W-1:0]      dvd_r, dvd_nxt;
  logic [msf_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r, done_r;
  logic [msf_pkg::DVS_W:0]       rem_t;
  logic                          ge;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    rem_t   = {rem_r, dvd_r[msf_pkg::DV_W-1]};
    ge      = rem_t >= {1'b0, dvs_r};
    rem_nxt = ge ? msf_pkg::DVS_W'(rem_t - {1'b0, dvs_r}) : rem_t[msf_pkg::DVS_W-1:0];
    dvd_nxt = {dvd_r[msf_pkg::DV_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == msf_pkg::DIV_CNT_W'(msf_pkg::DV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r <= req.divisor;
      dvd_r <= req.dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

// File: rtl/mean_shift_pixel_filter_core.sv
// ----------------------------------------------------------------------------
// mean_shift_pixel_filter_core
// Mean-shift filter of single pixels over a Lab frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): op 0 writes one Lab pixel into the
//   frame store and gives no result. op 1 runs mean-shift from the named
//   pixel; a pixel outside the frame in use is dropped.
//   Result channel (out_valid/out_ready): one word per filter item with the
//   converged mode and the number of passes. The mode is also written back.
//   Configuration (cfg_we/cfg_idx/cfg_wdata) is to be written only while idle;
//   the block itself does not enforce this. A filter item runs up to
//   MAX_PASSES passes over the clipped window (up to 961 pixels). The
//   window scan reads one pixel a cycle from the single frame store read
//   port; the five rounded means go through one bit-serial divider.
//   The block takes one filter item at a time; a load leaves it ready for the next word.
//   A finished result sits in the output register; the next item is accepted
//   meanwhile, and a later result waits until the receiver takes the first.
//   Reset clears control and restores the register defaults; the frame store
//   holds no defined value until written.
// ----------------------------------------------------------------------------
module mean_shift_pixel_filter_core #(
  parameter int MAX_WIDTH  = msf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = msf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_PASSES = msf_pkg::MAX_PASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [msf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [7:0]                        in_row,
  input  logic [7:0]                        in_col,
  input  logic signed [15:0]                in_lum_in,
  input  logic signed [15:0]                in_chroma_a_in,
  input  logic signed [15:0]                in_chroma_b_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_row_out,
  output logic [7:0]                        out_col_out,
  output logic signed [15:0]                out_lum_mode,
  output logic signed [15:0]                out_chroma_a_mode,
  output logic signed [15:0]                out_chroma_b_mode,
  output logic [6:0]                        out_passes
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int PW = msf_pkg::PIX_W;
  localparam int CW = msf_pkg::CRD_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MODE   = 4'd1;
  localparam logic [3:0] S_SETUP  = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_EVAL   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // Configuration registers
  logic [msf_pkg::RAD_W-1:0]      rad_r;
  logic [msf_pkg::CFG_DATA_W-1:0] crad_r;
  logic [msf_pkg::DIM_W-1:0]      fw_r, fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r  <= msf_pkg::RAD_RST;
      crad_r <= msf_pkg::CRAD_RST;
      fw_r   <= msf_pkg::DIM_RST;
      fh_r   <= msf_pkg::DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        msf_pkg::CFG_SPATIAL_RADIUS:  rad_r  <= cfg_wdata[msf_pkg::RAD_W-1:0];
        msf_pkg::CFG_COLOR_RADIUS_SQ: crad_r <= cfg_wdata;
        msf_pkg::CFG_FRAME_WIDTH:     fw_r   <= cfg_wdata[msf_pkg::DIM_W-1:0];
        msf_pkg::CFG_FRAME_HEIGHT:    fh_r   <= cfg_wdata[msf_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size in use
  logic [CW:0] w_dim, h_dim;
  always_comb begin
    if (fw_r == '0)                  w_dim = (CW+1)'(1);
    else if (32'(fw_r) > MAX_WIDTH)  w_dim = (CW+1)'(MAX_WIDTH);
    else                             w_dim = {1'b0, fw_r};
    if (fh_r == '0)                  h_dim = (CW+1)'(1);
    else if (32'(fh_r) > MAX_HEIGHT) h_dim = (CW+1)'(MAX_HEIGHT);
    else                             h_dim = {1'b0, fh_r};
  end

  // State
  logic [3:0]   state_r, state_nxt;
  logic [AW-1:0] addr_r;
  logic [7:0]   row_r, col_r;
  logic [CW-1:0] mr_r, mc_r;
  logic signed [PW-1:0] ml_r, ma_r, mb_r;
  logic [msf_pkg::PASS_W-1:0] passes_r;
  logic [CW-1:0] sr_r, sc_r, c0_r, c1_r, r1_r;
  logic [2:0]   k_r;

  // Frame store
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [msf_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

  msf_fmem #(.DEPTH(DEPTH), .AW(AW)) u_fmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [31:0] full;
    full = 32'(r) * 32'(MAX_WIDTH) + 32'(c);
    return full[AW-1:0];
  endfunction

  logic in_fire, is_load, load_ok, filt_ok, done_fire;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign is_load   = !in_op;
  assign load_ok   = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);
  assign filt_ok   = ({2'b0, in_row} < h_dim) && ({2'b0, in_col} < w_dim);
  assign done_fire = (state_r == S_DONE) && (!out_valid || out_ready);

  // Route memory ports: load or write-back, then item or scan read
  always_comb begin
    mem_we    = (in_fire && is_load && load_ok) || done_fire;
    mem_waddr = done_fire ? addr_r : addr_of({1'b0, in_row}, {1'b0, in_col});
    mem_wdata = done_fire ? {ml_r, ma_r, mb_r} : {in_lum_in, in_chroma_a_in, in_chroma_b_in};
    mem_raddr = (state_r == S_IDLE) ? addr_of({1'b0, in_row}, {1'b0, in_col})
                                    : addr_of(sr_r, sc_r);
  end

  // Window bounds around the current spatial mode
  logic [CW-1:0] r0_w, r1_w, c0_w, c1_w;
  logic [CW:0]   rs_sum, cs_sum, hm1, wm1;
  always_comb begin
    hm1    = h_dim - 1'b1;
    wm1    = w_dim - 1'b1;
    rs_sum = {1'b0, mr_r} + (CW+1)'(rad_r);
    cs_sum = {1'b0, mc_r} + (CW+1)'(rad_r);
    r0_w   = (mr_r < CW'(rad_r)) ? '0 : mr_r - CW'(rad_r);
    c0_w   = (mc_r < CW'(rad_r)) ? '0 : mc_r - CW'(rad_r);
    r1_w   = (rs_sum > hm1) ? hm1[CW-1:0] : rs_sum[CW-1:0];
    c1_w   = (cs_sum > wm1) ? wm1[CW-1:0] : cs_sum[CW-1:0];
  end

  // Scan pipeline: read, square, accumulate
  logic p1_v_r, p2_v_r;
  logic [CW-1:0] p1_r_r, p1_c_r, p2_r_r, p2_c_r;
  logic signed [PW-1:0] p2_l_r, p2_a_r, p2_b_r;
  logic [msf_pkg::SQ_W-1:0] p2_sq0_r, p2_sq1_r, p2_sq2_r;
  logic [msf_pkg::SUM_W-1:0] acc_r_r, acc_c_r;
  logic signed [msf_pkg::ACC_W-1:0] acc_l_r, acc_a_r, acc_b_r;
  logic [msf_pkg::CNT_W-1:0] acc_n_r;

  logic signed [PW-1:0] q_l, q_a, q_b;
  logic signed [PW:0]   dl, da, db;
  logic signed [2*PW+1:0] pl, pa, pb;
  logic [msf_pkg::DIST_W-1:0] cdist;
  logic scan_last, hit;

  always_comb begin
    q_l  = mem_rdata[3*PW-1:2*PW];
    q_a  = mem_rdata[2*PW-1:PW];
    q_b  = mem_rdata[PW-1:0];
    dl   = {q_l[PW-1], q_l} - {ml_r[PW-1], ml_r};
    da   = {q_a[PW-1], q_a} - {ma_r[PW-1], ma_r};
    db   = {q_b[PW-1], q_b} - {mb_r[PW-1], mb_r};
    pl   = dl * dl;
    pa   = da * da;
    pb   = db * db;
    cdist = msf_pkg::DIST_W'(p2_sq0_r) + msf_pkg::DIST_W'(p2_sq1_r)
          + msf_pkg::DIST_W'(p2_sq2_r);
    hit  = p2_v_r && (cdist <= crad_r);
    scan_last = (sr_r == r1_r) && (sc_r == c1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == S_SCAN);
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r_r   <= sr_r;
    p1_c_r   <= sc_r;
    p2_r_r   <= p1_r_r;
    p2_c_r   <= p1_c_r;
    p2_l_r   <= q_l;
    p2_a_r   <= q_a;
    p2_b_r   <= q_b;
    p2_sq0_r <= pl[msf_pkg::SQ_W-1:0];
    p2_sq1_r <= pa[msf_pkg::SQ_W-1:0];
    p2_sq2_r <= pb[msf_pkg::SQ_W-1:0];
  end

  // Divider operands for the five rounded means
  msf_pkg::div_req_t div_req;
  msf_pkg::div_rsp_t div_rsp;

  msf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  logic signed [msf_pkg::ACC_W-1:0] sel_s;
  logic [msf_pkg::ACC_W-1:0] sel_mag;
  logic sel_neg;
  always_comb begin
    unique case (k_r)
      3'd0:    sel_s = msf_pkg::ACC_W'(acc_r_r);
      3'd1:    sel_s = msf_pkg::ACC_W'(acc_c_r);
      3'd2:    sel_s = acc_l_r;
      3'd3:    sel_s = acc_a_r;
      default: sel_s = acc_b_r;
    endcase
    sel_neg = sel_s[msf_pkg::ACC_W-1];
    sel_mag = sel_neg ? msf_pkg::ACC_W'(-sel_s) : sel_s;
    div_req.start    = (state_r == S_DSTART);
    div_req.dividend = msf_pkg::DV_W'({sel_mag, 1'b0}) + msf_pkg::DV_W'(acc_n_r);
    div_req.divisor  = {acc_n_r, 1'b0};
  end

  logic [PW:0] q_mag, q_sgn;
  assign q_mag = div_rsp.quotient[PW:0];
  assign q_sgn = sel_neg ? (PW+1)'(-q_mag) : q_mag;

  // New mode and squared shift
  logic [CW-1:0] nr_r, nc_r;
  logic signed [PW-1:0] nl_r, na_r, nb_r;
  logic [msf_pkg::SHIFT_W-1:0] shift_r;
  logic signed [PW:0] sd;
  logic signed [2*PW+1:0] sp;
  logic [msf_pkg::SHIFT_W-1:0] sterm;
  always_comb begin
    unique case (k_r)
      3'd0:    sd = $signed({{(PW+1-CW){1'b0}}, nr_r}) - $signed({{(PW+1-CW){1'b0}}, mr_r});
      3'd1:    sd = $signed({{(PW+1-CW){1'b0}}, nc_r}) - $signed({{(PW+1-CW){1'b0}}, mc_r});
      3'd2:    sd = {nl_r[PW-1], nl_r} - {ml_r[PW-1], ml_r};
      3'd3:    sd = {na_r[PW-1], na_r} - {ma_r[PW-1], ma_r};
      default: sd = {nb_r[PW-1], nb_r} - {mb_r[PW-1], mb_r};
    endcase
    sp    = sd * sd;
    sterm = (k_r < 3'd2) ? {sp[msf_pkg::SHIFT_W-17:0], 16'b0}
                         : msf_pkg::SHIFT_W'(sp[msf_pkg::SQ_W-1:0]);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire && !is_load && filt_ok) state_nxt = S_MODE;
      S_MODE:   state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (!p1_v_r && !p2_v_r) state_nxt = (acc_n_r == '0) ? S_DONE : S_DSTART;
      end
      S_DSTART: state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) state_nxt = (k_r == 3'd4) ? S_SHIFT : S_DSTART;
      end
      S_SHIFT:  if (k_r == 3'd4) state_nxt = S_EVAL;
      S_EVAL: begin
        if (shift_r <= msf_pkg::SHIFT_LIMIT ||
            passes_r == msf_pkg::PASS_W'(MAX_PASSES)) state_nxt = S_DONE;
        else state_nxt = S_SETUP;
      end
      S_DONE:   if (done_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers of the iteration
  always_ff @(posedge clk) begin
    // accumulate qualifying pixels
    if (hit) begin
      acc_r_r <= acc_r_r + msf_pkg::SUM_W'(p2_r_r);
      acc_c_r <= acc_c_r + msf_pkg::SUM_W'(p2_c_r);
      acc_l_r <= acc_l_r + msf_pkg::ACC_W'(p2_l_r);
      acc_a_r <= acc_a_r + msf_pkg::ACC_W'(p2_a_r);
      acc_b_r <= acc_b_r + msf_pkg::ACC_W'(p2_b_r);
      acc_n_r <= acc_n_r + 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        row_r    <= in_row;
        col_r    <= in_col;
        mr_r     <= {1'b0, in_row};
        mc_r     <= {1'b0, in_col};
        addr_r   <= addr_of({1'b0, in_row}, {1'b0, in_col});
        passes_r <= '0;
      end
      S_MODE: begin
        ml_r <= q_l;
        ma_r <= q_a;
        mb_r <= q_b;
      end
      S_SETUP: begin
        sr_r     <= r0_w;
        sc_r     <= c0_w;
        c0_r     <= c0_w;
        c1_r     <= c1_w;
        r1_r     <= r1_w;
        passes_r <= passes_r + 1'b1;
        acc_r_r  <= '0;
        acc_c_r  <= '0;
        acc_l_r  <= '0;
        acc_a_r  <= '0;
        acc_b_r  <= '0;
        acc_n_r  <= '0;
        k_r      <= '0;
      end
      S_SCAN: begin
        if (sc_r == c1_r) begin
          sc_r <= c0_r;
          sr_r <= sr_r + 1'b1;
        end else begin
          sc_r <= sc_r + 1'b1;
        end
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          unique case (k_r)
            3'd0:    nr_r <= q_mag[CW-1:0];
            3'd1:    nc_r <= q_mag[CW-1:0];
            3'd2:    nl_r <= q_sgn[PW-1:0];
            3'd3:    na_r <= q_sgn[PW-1:0];
            default: nb_r <= q_sgn[PW-1:0];
          endcase
          k_r     <= (k_r == 3'd4) ? 3'd0 : k_r + 1'b1;
          shift_r <= '0;
        end
      end
      S_SHIFT: begin
        shift_r <= shift_r + sterm;
        k_r     <= k_r + 1'b1;
      end
      S_EVAL: begin
        mr_r <= nr_r;
        mc_r <= nc_r;
        ml_r <= nl_r;
        ma_r <= na_r;
        mb_r <= nb_r;
      end
      default: ;
    endcase
  end

  // Output register
  logic out_valid_r, out_valid_nxt;
  logic [7:0] orow_r, ocol_r;
  logic signed [PW-1:0] ol_r, oa_r, ob_r;
  logic [6:0] opass_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_fire)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      orow_r  <= row_r;
      ocol_r  <= col_r;
      ol_r    <= ml_r;
      oa_r    <= ma_r;
      ob_r    <= mb_r;
      opass_r <= passes_r[6:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_out       = orow_r;
  assign out_col_out       = ocol_r;
  assign out_lum_mode      = ol_r;
  assign out_chroma_a_mode = oa_r;
  assign out_chroma_b_mode = ob_r;
  assign out_passes        = opass_r;

endmodule

// File: rtl/msf_checker.sv
// ----------------------------------------------------------------------------
// msf_checker
// Port-level checks of the mean-shift pixel filter, bound to the top level.
// ----------------------------------------------------------------------------
module msf_checker #(
  parameter int MAX_PASSES = msf_pkg::MAX_PASSES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_row_out,
  input logic [15:0] out_lum_mode,
  input logic [6:0]  out_passes
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_out)
                                && $stable(out_lum_mode) && $stable(out_passes))
    else $error("stalled result word changed");

  // Every result reports at least one pass and no more than the limit
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_passes != 7'd0 && 32'(out_passes) <= MAX_PASSES)
    else $error("pass count out of range");

  // A load never makes the block busy
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("block busy after a load word");

endmodule

bind mean_shift_pixel_filter_core msf_checker #(.MAX_PASSES(MAX_PASSES)) u_msf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_row_out  (out_row_out),
  .out_lum_mode (out_lum_mode),
  .out_passes   (out_passes)
);
